// ===== sv/dtf_pkg.sv =====
// dtf_pkg: shared widths, character codes and number-format constants
// for the decimal text to float core; no dependencies
package dtf_pkg;

    localparam int CH_W      = 8;
    localparam int VALUE_W   = 32;
    localparam int MAX_CHARS = 16;
    localparam int EXP_CAP   = 400;
    localparam int CIDX_W    = $clog2(MAX_CHARS + 1);
    localparam int K_W       = $clog2(EXP_CAP + 1);
    localparam int EXP_W     = 13;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UE    = 8'h45;
    localparam logic [CH_W-1:0] CH_LE    = 8'h65;

    // double mantissas with hidden bit at 52, exponent of that bit
    localparam logic [52:0] ONE_MANT = 53'd1 << 52;
    localparam logic [52:0] E8_MANT  = 53'd100000000 << 26;
    localparam logic [52:0] TEN_MANT = 53'd10 << 49;
    localparam logic signed [EXP_W-1:0] E8_EXP  = 13'sd26;
    localparam logic signed [EXP_W-1:0] TEN_EXP = 13'sd3;

    localparam logic signed [EXP_W-1:0] E_DBL_OVF = 13'sd1024;
    localparam logic signed [EXP_W-1:0] E_F_MAX   = 13'sd127;
    localparam logic signed [EXP_W-1:0] E_F_MIN   = -13'sd126;
    localparam logic signed [EXP_W-1:0] E_F_ZERO  = -13'sd152;
    localparam logic signed [EXP_W-1:0] E_F_BIAS1 = 13'sd126;

    localparam logic [VALUE_W-1:0] F_NAN = 32'h7FC00000;
    localparam logic [VALUE_W-1:0] F_INF = 32'h7F800000;

endpackage

// ===== sv/dtf_char_if.sv =====
// dtf_char_if: input character channel, valid/ready with one character a beat
// depends on dtf_pkg
interface dtf_char_if;
    import dtf_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== sv/dtf_result_if.sv =====
// dtf_result_if: result channel, valid/ready with float bits and mark flag
// depends on dtf_pkg
interface dtf_result_if;
    import dtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_bits;
    logic               is_float;

    modport source (output valid, output value_bits, output is_float, input ready);
    modport sink   (input valid, input value_bits, input is_float, output ready);
endinterface

// ===== sv/decimal_text_to_float_core.sv =====
// decimal_text_to_float_core: a non-last character beat only updates the parse
// state; a last beat starts a conversion by one shared normalize/round unit, a
// radix-256 multiplier and a one-bit divider in a sequencer that scales by 1e8
// and 10 steps; ready is low meanwhile
// i_rst_n is synchronous active low and clears parse state and the output beat
// depends on dtf_pkg, dtf_char_if, dtf_result_if
module decimal_text_to_float_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dtf_char_if.sink            i_char,
    dtf_result_if.source        o_result
);
    import dtf_pkg::*;

    typedef enum logic [2:0] {
        PH_SIGN, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG, PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_CVT_INT, S_CVT_FRAC, S_CVT_DIV, S_QUOT, S_DIV_RUN, S_ADD,
        S_ALIGN, S_SUM, S_SCALE_INIT, S_SCALE_STEP, S_MUL_RUN, S_FINAL, S_F32,
        S_F32_SHIFT, S_PACK, S_NORM, S_ROUND, S_OUT
    } t_state;

    typedef enum logic [1:0] {D_A, D_B, D_S} t_dst;

    function automatic logic [31:0] acc10(input logic [31:0] x, input logic [3:0] d);
        acc10 = {x[28:0], 3'b0} + {x[30:0], 1'b0} + {28'b0, d};
    endfunction

    // parse state
    t_phase              r_phase, n_phase, p_ph;
    logic [31:0]         r_int, n_int, r_frac, n_frac, r_div, n_div, r_exp, n_exp;
    logic                r_vneg, n_vneg, r_eneg, n_eneg, r_fmark, n_fmark;
    logic                r_nul, n_nul, p_hit;
    logic [CIDX_W-1:0]   r_cidx, n_cidx;
    logic                c_dig, c_sign, c_minus, c_dot, c_e;
    logic [3:0]          c_d;

    // sequencer and arithmetic
    t_state                    r_state, r_ret;
    t_dst                      r_dst;
    logic [65:0]               r_m;
    logic signed [EXP_W-1:0]   r_e, r_tgt, r_ope;
    logic                      r_st, r_big_a;
    logic [52:0]               r_am, r_bm, r_sm;
    logic signed [EXP_W-1:0]   r_ae, r_be, r_se;
    logic                      r_az, r_sinf;
    logic [K_W-1:0]            r_k;
    logic [52:0]               r_mpa;
    logic [55:0]               r_mpb, r_plo;
    logic [53:0]               r_acc;
    logic [2:0]                r_mcnt;
    logic [53:0]               r_rem;
    logic [52:0]               r_dvs;
    logic [54:0]               r_q;
    logic [5:0]                r_dcnt;
    logic [VALUE_W-1:0]        r_res, r_obits;
    logic                      r_ovalid, r_ofloat;

    logic [60:0]               mul_pp;
    logic [61:0]               mul_sum;
    logic [105:0]              prod;
    logic                      div_ge;
    logic [53:0]               div_sub;
    logic [52:0]               rnd_mant;
    logic                      rnd_up;
    logic [53:0]               rnd_sum;
    logic [23:0]               f_mant;
    logic                      f_up;
    logic signed [EXP_W-1:0]   f_ef;
    logic [VALUE_W-1:0]        f_bits;
    logic [K_W-1:0]            k_init;

    assign i_char.ready        = (r_state == S_IDLE);
    assign o_result.valid      = r_ovalid;
    assign o_result.value_bits = r_obits;
    assign o_result.is_float   = r_ofloat;

    assign c_dig   = (i_char.ch >= CH_ZERO) && (i_char.ch <= CH_NINE);
    assign c_d     = c_dig ? 4'(i_char.ch - CH_ZERO) : 4'd0;
    assign c_minus = (i_char.ch == CH_MINUS);
    assign c_sign  = (i_char.ch == CH_PLUS) || c_minus;
    assign c_dot   = (i_char.ch == CH_DOT);
    assign c_e     = (i_char.ch == CH_LE) || (i_char.ch == CH_UE);

    always_comb begin
        n_phase = r_phase;
        n_int   = r_int;
        n_frac  = r_frac;
        n_div   = r_div;
        n_exp   = r_exp;
        n_vneg  = r_vneg;
        n_eneg  = r_eneg;
        n_fmark = r_fmark;
        n_nul   = r_nul;
        n_cidx  = r_cidx;
        p_ph    = r_phase;
        p_hit   = 1'b0;
        if (r_cidx < CIDX_W'(MAX_CHARS)) begin
            n_cidx = r_cidx + 1'b1;
            if (!r_nul) begin
                if (i_char.ch == CH_NUL) begin
                    n_nul   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    if (c_dot || c_e) begin
                        n_fmark = 1'b1;
                    end
                    if (p_ph == PH_SIGN) begin
                        p_ph = PH_INT;
                        if (c_sign) begin
                            n_vneg = c_minus;
                            p_hit  = 1'b1;
                        end
                    end
                    if (!p_hit && p_ph == PH_INT) begin
                        p_hit = 1'b1;
                        if (c_dig) begin
                            n_int = acc10(r_int, c_d);
                        end else if (c_dot) begin
                            p_ph = PH_FRAC;
                        end else if (c_e) begin
                            p_ph = PH_ESIGN;
                        end else begin
                            p_ph = PH_DONE;
                        end
                    end
                    if (!p_hit && p_ph == PH_FRAC) begin
                        p_hit = 1'b1;
                        if (c_dig) begin
                            n_frac = acc10(r_frac, c_d);
                            n_div  = acc10(r_div, 4'd0);
                        end else if (c_e) begin
                            p_ph = PH_ESIGN;
                        end else begin
                            p_ph = PH_DONE;
                        end
                    end
                    if (!p_hit && p_ph == PH_ESIGN) begin
                        p_ph = PH_EDIG;
                        if (c_sign) begin
                            n_eneg = c_minus;
                            p_hit  = 1'b1;
                        end
                    end
                    if (!p_hit && p_ph == PH_EDIG) begin
                        p_hit = 1'b1;
                        if (c_dig) begin
                            n_exp = acc10(r_exp, c_d);
                        end else begin
                            p_ph = PH_DONE;
                        end
                    end
                    if (!p_hit) begin
                        p_ph = PH_DONE;
                    end
                    n_phase = p_ph;
                end
            end
        end
    end

    // shared datapath pieces
    assign mul_pp   = r_mpa * r_mpb[7:0];
    assign mul_sum  = {8'b0, r_acc} + {1'b0, mul_pp};
    assign prod     = {r_acc[49:0], r_plo};
    assign div_ge   = r_rem >= {1'b0, r_dvs};
    assign div_sub  = div_ge ? (r_rem - {1'b0, r_dvs}) : r_rem;
    assign rnd_mant = r_m[64:12];
    assign rnd_up   = r_m[11] & ((|r_m[10:0]) | r_st | rnd_mant[0]);
    assign rnd_sum  = {1'b0, rnd_mant} + {53'b0, rnd_up};
    assign f_mant   = r_m[64:41];
    assign f_up     = r_m[40] & ((|r_m[39:0]) | r_st | f_mant[0]);
    assign f_ef     = r_e + E_F_BIAS1;
    assign f_bits   = {1'b0, f_ef[7:0], 23'b0} + {8'b0, f_mant} + {31'b0, f_up};
    assign k_init   = (r_exp > 32'(EXP_CAP)) ? K_W'(EXP_CAP) : r_exp[K_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_phase  <= PH_SIGN;
            r_int    <= '0;
            r_frac   <= '0;
            r_div    <= 32'd1;
            r_exp    <= '0;
            r_vneg   <= 1'b0;
            r_eneg   <= 1'b0;
            r_fmark  <= 1'b0;
            r_nul    <= 1'b0;
            r_cidx   <= '0;
        end else begin
            if (r_ovalid && o_result.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_char.valid) begin
                        r_phase <= n_phase;
                        r_int   <= n_int;
                        r_frac  <= n_frac;
                        r_div   <= n_div;
                        r_exp   <= n_exp;
                        r_vneg  <= n_vneg;
                        r_eneg  <= n_eneg;
                        r_fmark <= n_fmark;
                        r_nul   <= n_nul;
                        r_cidx  <= n_cidx;
                        if (i_char.last) begin
                            r_state <= S_CVT_INT;
                        end
                    end
                end
                S_CVT_INT: begin
                    if (r_int == 32'd0) begin
                        r_az    <= 1'b1;
                        r_state <= S_CVT_FRAC;
                    end else begin
                        r_az    <= 1'b0;
                        r_m     <= {1'b0, r_int, 33'b0};
                        r_e     <= 13'sd31;
                        r_st    <= 1'b0;
                        r_dst   <= D_A;
                        r_ret   <= S_CVT_FRAC;
                        r_state <= S_NORM;
                    end
                end
                S_CVT_FRAC: begin
                    if (r_div == 32'd0 || r_frac == 32'd0) begin
                        r_state <= S_SCALE_INIT;
                    end else begin
                        r_m     <= {1'b0, r_frac, 33'b0};
                        r_e     <= 13'sd31;
                        r_st    <= 1'b0;
                        r_dst   <= D_B;
                        r_ret   <= S_CVT_DIV;
                        r_state <= S_NORM;
                    end
                end
                S_CVT_DIV: begin
                    r_m     <= {1'b0, r_div, 33'b0};
                    r_e     <= 13'sd31;
                    r_st    <= 1'b0;
                    r_dst   <= D_S;
                    r_ret   <= S_QUOT;
                    r_state <= S_NORM;
                end
                S_QUOT: begin
                    r_rem   <= {1'b0, r_bm};
                    r_dvs   <= r_sm;
                    r_dcnt  <= '0;
                    r_ope   <= r_be - r_se;
                    r_dst   <= D_B;
                    r_ret   <= S_ADD;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    if (r_dcnt == 6'd55) begin
                        r_m     <= {1'b0, r_q, 10'b0};
                        r_e     <= r_ope;
                        r_st    <= (r_rem != '0);
                        r_state <= S_NORM;
                    end else begin
                        r_rem  <= {div_sub[52:0], 1'b0};
                        r_q    <= {r_q[53:0], div_ge};
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_ADD: begin
                    if (r_az) begin
                        r_am    <= r_bm;
                        r_ae    <= r_be;
                        r_az    <= 1'b0;
                        r_state <= S_SCALE_INIT;
                    end else if (r_ae >= r_be) begin
                        r_m     <= {1'b0, r_bm, 12'b0};
                        r_e     <= r_be;
                        r_tgt   <= r_ae;
                        r_big_a <= 1'b1;
                        r_st    <= 1'b0;
                        r_state <= S_ALIGN;
                    end else begin
                        r_m     <= {1'b0, r_am, 12'b0};
                        r_e     <= r_ae;
                        r_tgt   <= r_be;
                        r_big_a <= 1'b0;
                        r_st    <= 1'b0;
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    if (r_e == r_tgt) begin
                        r_state <= S_SUM;
                    end else begin
                        r_st <= r_st | r_m[0];
                        r_m  <= r_m >> 1;
                        r_e  <= r_e + 13'sd1;
                    end
                end
                S_SUM: begin
                    r_m     <= r_m + {1'b0, (r_big_a ? r_am : r_bm), 12'b0};
                    r_dst   <= D_A;
                    r_ret   <= S_SCALE_INIT;
                    r_state <= S_NORM;
                end
                S_SCALE_INIT: begin
                    r_sm    <= ONE_MANT;
                    r_se    <= '0;
                    r_sinf  <= 1'b0;
                    r_k     <= k_init;
                    r_state <= S_SCALE_STEP;
                end
                S_SCALE_STEP: begin
                    if (r_se >= E_DBL_OVF) begin
                        r_sinf  <= 1'b1;
                        r_state <= S_FINAL;
                    end else if (r_k == '0) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_mpa  <= r_sm;
                        r_acc  <= '0;
                        r_plo  <= '0;
                        r_mcnt <= '0;
                        r_dst  <= D_S;
                        r_ret  <= S_SCALE_STEP;
                        if (r_k >= K_W'(8)) begin
                            r_mpb <= {3'b0, E8_MANT};
                            r_ope <= r_se + E8_EXP;
                            r_k   <= r_k - K_W'(8);
                        end else begin
                            r_mpb <= {3'b0, TEN_MANT};
                            r_ope <= r_se + TEN_EXP;
                            r_k   <= r_k - K_W'(1);
                        end
                        r_state <= S_MUL_RUN;
                    end
                end
                S_MUL_RUN: begin
                    if (r_mcnt == 3'd7) begin
                        r_m     <= prod[105:40];
                        r_st    <= |prod[39:0];
                        r_e     <= r_ope;
                        r_state <= S_NORM;
                    end else begin
                        r_acc  <= mul_sum[61:8];
                        r_plo  <= {mul_sum[7:0], r_plo[55:8]};
                        r_mpb  <= r_mpb >> 8;
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                S_FINAL: begin
                    if (r_az) begin
                        r_res   <= (!r_eneg && r_sinf) ? F_NAN : {r_vneg, 31'b0};
                        r_state <= S_OUT;
                    end else if (r_sinf) begin
                        r_res   <= r_eneg ? {r_vneg, 31'b0} : (F_INF | {r_vneg, 31'b0});
                        r_state <= S_OUT;
                    end else if (r_eneg) begin
                        r_rem   <= {1'b0, r_am};
                        r_dvs   <= r_sm;
                        r_dcnt  <= '0;
                        r_ope   <= r_ae - r_se;
                        r_dst   <= D_A;
                        r_ret   <= S_F32;
                        r_state <= S_DIV_RUN;
                    end else begin
                        r_mpa   <= r_am;
                        r_mpb   <= {3'b0, r_sm};
                        r_acc   <= '0;
                        r_plo   <= '0;
                        r_mcnt  <= '0;
                        r_ope   <= r_ae + r_se;
                        r_dst   <= D_A;
                        r_ret   <= S_F32;
                        r_state <= S_MUL_RUN;
                    end
                end
                S_F32: begin
                    if (r_ae > E_F_MAX) begin
                        r_res   <= F_INF | {r_vneg, 31'b0};
                        r_state <= S_OUT;
                    end else if (r_ae < E_F_ZERO) begin
                        r_res   <= {r_vneg, 31'b0};
                        r_state <= S_OUT;
                    end else begin
                        r_m     <= {1'b0, r_am, 12'b0};
                        r_e     <= r_ae;
                        r_st    <= 1'b0;
                        r_state <= S_F32_SHIFT;
                    end
                end
                S_F32_SHIFT: begin
                    if (r_e < E_F_MIN) begin
                        r_st <= r_st | r_m[0];
                        r_m  <= r_m >> 1;
                        r_e  <= r_e + 13'sd1;
                    end else begin
                        r_state <= S_PACK;
                    end
                end
                S_PACK: begin
                    r_res   <= f_bits | {r_vneg, 31'b0};
                    r_state <= S_OUT;
                end
                S_NORM: begin
                    if (r_m[65]) begin
                        r_st <= r_st | r_m[0];
                        r_m  <= r_m >> 1;
                        r_e  <= r_e + 13'sd1;
                    end else if (!r_m[64]) begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 13'sd1;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    unique case (r_dst)
                        D_A: begin
                            r_am <= rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
                            r_ae <= rnd_sum[53] ? r_e + 13'sd1 : r_e;
                        end
                        D_B: begin
                            r_bm <= rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
                            r_be <= rnd_sum[53] ? r_e + 13'sd1 : r_e;
                        end
                        D_S: begin
                            r_sm <= rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
                            r_se <= rnd_sum[53] ? r_e + 13'sd1 : r_e;
                        end
                        default: begin
                            r_am <= r_am;
                        end
                    endcase
                    r_state <= r_ret;
                end
                S_OUT: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_obits  <= r_res;
                        r_ofloat <= r_fmark;
                        r_ovalid <= 1'b1;
                        r_phase  <= PH_SIGN;
                        r_int    <= '0;
                        r_frac   <= '0;
                        r_div    <= 32'd1;
                        r_exp    <= '0;
                        r_vneg   <= 1'b0;
                        r_eneg   <= 1'b0;
                        r_fmark  <= 1'b0;
                        r_nul    <= 1'b0;
                        r_cidx   <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
